[design/nfcs_pkg.sv]
package nfcs_pkg;

	localparam int AddressBitsDefault = 24;
	localparam int ToggleBitDefault   = 6;

	localparam int ByteAddrW = 24;
	localparam int WordAddrW = 23;
	localparam int DataW     = 16;

	// input selector codes
	localparam logic [1:0] ModeProgram  = 2'd0;
	localparam logic [1:0] ModeErase    = 2'd1;
	localparam logic [1:0] ModeReadId   = 2'd2;
	localparam logic [1:0] ModeResponse = 2'd3;

	// result kind codes
	localparam logic [1:0] KindWrite = 2'd0;
	localparam logic [1:0] KindRead  = 2'd1;
	localparam logic [1:0] KindDone  = 2'd2;
	localparam logic [1:0] KindId    = 2'd3;

	// phase codes
	localparam logic [1:0] PhIdle = 2'd0;
	localparam logic [1:0] PhPoll = 2'd1;
	localparam logic [1:0] PhId   = 2'd2;

	localparam logic [WordAddrW-1:0] UnlockAddrA = 23'h555;
	localparam logic [WordAddrW-1:0] UnlockAddrB = 23'h2AA;
	localparam logic [DataW-1:0]     CmdUnlockA  = 16'h00AA;
	localparam logic [DataW-1:0]     CmdUnlockB  = 16'h0055;
	localparam logic [DataW-1:0]     CmdProgram  = 16'h00A0;
	localparam logic [DataW-1:0]     CmdErase    = 16'h0080;
	localparam logic [DataW-1:0]     CmdSector   = 16'h0030;
	localparam logic [DataW-1:0]     CmdAutoSel  = 16'h0090;
	localparam logic [DataW-1:0]     CmdReset    = 16'h00F0;

	typedef struct packed {
		logic [1:0]           phase;
		logic                 prev_toggle;
		logic [WordAddrW-1:0] pend_wa;
		logic                 resp_seen;
	} state_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [WordAddrW-1:0] word_address;
		logic [DataW-1:0]     bus_data;
	} result_t;

	function automatic result_t make_res(logic [1:0] kind, logic [WordAddrW-1:0] addr,
			logic [DataW-1:0] data);
		result_t r;
		r.kind         = kind;
		r.word_address = addr;
		r.bus_data     = data;
		return r;
	endfunction

endpackage

[design/nor_flash_command_sequencer_unit.sv]
// A request is captured in the input register, and its results are registered in
// the output register. A request that causes k results (k up to 8) holds the input
// register until its last result is loaded, one result per cycle while the output
// is not stalled; requests with no result retire at once and can follow back to back.
// Reset: arst_n low clears the phase, toggle, address and response state and
// empties the input and output registers at once.
module nor_flash_command_sequencer_unit #(
	parameter int ADDRESS_BITS = nfcs_pkg::AddressBitsDefault,
	parameter int TOGGLE_BIT   = nfcs_pkg::ToggleBitDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [23:0] byte_address, [39:24] data_word
	input  logic [1:0]  s_axis_tuser,  // [1:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [22:0] word_address, [38:23] bus_data, [39] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast
);

	localparam logic [63:0] FullMask = (64'd1 << ADDRESS_BITS) - 64'd1;
	localparam logic [nfcs_pkg::ByteAddrW-1:0] AddrMask = FullMask[nfcs_pkg::ByteAddrW-1:0];

	logic                          in_valid_s1;
	logic [1:0]                    mode_s1;
	logic [nfcs_pkg::WordAddrW-1:0] wa_s1;
	logic [nfcs_pkg::DataW-1:0]    data_s1;

	nfcs_pkg::state_t  state_q;
	nfcs_pkg::state_t  nxt;
	nfcs_pkg::result_t res;
	logic [3:0]        count;
	logic [2:0]        idx_q;

	logic                  out_valid_q;
	nfcs_pkg::result_t     out_res_q;
	logic                  out_last_q;

	logic [nfcs_pkg::ByteAddrW-1:0] masked_ba;
	logic out_load;
	logic emit;
	logic final_idx;
	logic retire;
	logic accept;

	nfcs_decode #(
		.TOGGLE_BIT(TOGGLE_BIT)
	) u_decode (
		.mode     (mode_s1),
		.wa       (wa_s1),
		.data_word(data_s1),
		.st       (state_q),
		.idx      (idx_q),
		.count    (count),
		.res      (res),
		.nxt      (nxt)
	);

	assign masked_ba = s_axis_tdata[23:0] & AddrMask;

	assign out_load  = !out_valid_q || m_axis_tready;
	assign emit      = in_valid_s1 && (count != 4'd0) && out_load;
	assign final_idx = ({1'b0, idx_q} == (count - 4'd1));
	assign retire    = in_valid_s1 && ((count == 4'd0) || (out_load && final_idx));
	assign s_axis_tready = !in_valid_s1 || retire;
	assign accept    = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			idx_q       <= 3'd0;
			state_q     <= '{phase: nfcs_pkg::PhIdle, prev_toggle: 1'b0, pend_wa: '0,
				resp_seen: 1'b0};
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				in_valid_s1 <= 1'b1;
			else if (retire)
				in_valid_s1 <= 1'b0;
			if (retire) begin
				idx_q   <= 3'd0;
				state_q <= nxt;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (out_load)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= s_axis_tuser;
			wa_s1   <= masked_ba[nfcs_pkg::ByteAddrW-1:1];
			data_s1 <= s_axis_tdata[39:24];
		end
		if (emit) begin
			out_res_q  <= res;
			out_last_q <= final_idx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {1'b0, out_res_q.bus_data, out_res_q.word_address};

	// index never runs past the result count of the held request
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && (count != 4'd0) |-> ({1'b0, idx_q} < count))
		else $error("result index beyond count");

	a_idx_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 3'd0) |-> in_valid_s1)
		else $error("result index without a held request");

	a_state_on_retire: assert property (@(posedge clk) disable iff (!arst_n)
		!retire |=> $stable(state_q))
		else $error("state moved without a retiring request");

	a_resp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.resp_seen |-> (state_q.phase == nfcs_pkg::PhPoll ||
			state_q.phase == nfcs_pkg::PhId))
		else $error("response count set while idle");

endmodule

[design/nfcs_decode.sv]
// Works out how many results the held request causes, the result at a given
// index, and the state once the request has retired.
module nfcs_decode #(
	parameter int TOGGLE_BIT = nfcs_pkg::ToggleBitDefault
) (
	input  logic [1:0]                     mode,
	input  logic [nfcs_pkg::WordAddrW-1:0] wa,
	input  logic [nfcs_pkg::DataW-1:0]     data_word,
	input  nfcs_pkg::state_t               st,
	input  logic [2:0]                     idx,
	output logic [3:0]                     count,
	output nfcs_pkg::result_t              res,
	output nfcs_pkg::state_t               nxt
);

	logic idle;
	logic toggle;

	assign idle   = (st.phase != nfcs_pkg::PhPoll) && (st.phase != nfcs_pkg::PhId);
	assign toggle = data_word[TOGGLE_BIT];

	always_comb begin
		res   = nfcs_pkg::make_res(nfcs_pkg::KindWrite, '0, '0);
		count = 4'd0;
		nxt   = st;
		unique case (mode)
			nfcs_pkg::ModeProgram: begin
				if (idle) begin
					count           = 4'd6;
					nxt.phase       = nfcs_pkg::PhPoll;
					nxt.pend_wa     = wa;
					nxt.resp_seen   = 1'b0;
					nxt.prev_toggle = 1'b0;
					case (idx)
						3'd0: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdUnlockA);
						3'd1: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrB, nfcs_pkg::CmdUnlockB);
						3'd2: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdProgram);
						3'd3: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite, wa, data_word);
						default: res = nfcs_pkg::make_res(nfcs_pkg::KindRead, wa, '0);
					endcase
				end
			end
			nfcs_pkg::ModeErase: begin
				if (idle) begin
					count           = 4'd8;
					nxt.phase       = nfcs_pkg::PhPoll;
					nxt.pend_wa     = wa;
					nxt.resp_seen   = 1'b0;
					nxt.prev_toggle = 1'b0;
					case (idx)
						3'd0, 3'd3: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdUnlockA);
						3'd1, 3'd4: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrB, nfcs_pkg::CmdUnlockB);
						3'd2: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdErase);
						3'd5: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite, wa,
							nfcs_pkg::CmdSector);
						default: res = nfcs_pkg::make_res(nfcs_pkg::KindRead, wa, '0);
					endcase
				end
			end
			nfcs_pkg::ModeReadId: begin
				if (idle) begin
					count         = 4'd5;
					nxt.phase     = nfcs_pkg::PhId;
					nxt.resp_seen = 1'b0;
					case (idx)
						3'd0: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdUnlockA);
						3'd1: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrB, nfcs_pkg::CmdUnlockB);
						3'd2: res = nfcs_pkg::make_res(nfcs_pkg::KindWrite,
							nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdAutoSel);
						3'd3: res = nfcs_pkg::make_res(nfcs_pkg::KindRead, '0, '0);
						default: res = nfcs_pkg::make_res(nfcs_pkg::KindRead,
							nfcs_pkg::WordAddrW'(1), '0);
					endcase
				end
			end
			nfcs_pkg::ModeResponse: begin
				if (st.phase == nfcs_pkg::PhPoll) begin
					if (!st.resp_seen) begin
						// first status word only seeds the toggle reference
						nxt.prev_toggle = toggle;
						nxt.resp_seen   = 1'b1;
					end else if (toggle == st.prev_toggle) begin
						count         = 4'd1;
						res           = nfcs_pkg::make_res(nfcs_pkg::KindDone, st.pend_wa, '0);
						nxt.phase     = nfcs_pkg::PhIdle;
						nxt.resp_seen = 1'b0;
					end else begin
						count           = 4'd1;
						res             = nfcs_pkg::make_res(nfcs_pkg::KindRead, st.pend_wa, '0);
						nxt.prev_toggle = toggle;
					end
				end else if (st.phase == nfcs_pkg::PhId) begin
					if (!st.resp_seen) begin
						count         = 4'd1;
						res           = nfcs_pkg::make_res(nfcs_pkg::KindId, '0, data_word);
						nxt.resp_seen = 1'b1;
					end else begin
						count         = 4'd2;
						nxt.phase     = nfcs_pkg::PhIdle;
						nxt.resp_seen = 1'b0;
						if (idx == 3'd0)
							res = nfcs_pkg::make_res(nfcs_pkg::KindId,
								nfcs_pkg::WordAddrW'(1), data_word);
						else
							res = nfcs_pkg::make_res(nfcs_pkg::KindWrite, '0,
								nfcs_pkg::CmdReset);
					end
				end
			end
		endcase
	end

endmodule

[sim/nor_flash_command_sequencer_unit_tb.sv]
module nor_flash_command_sequencer_unit_tb;

	typedef struct packed {
		logic [1:0]                     kind;
		logic [nfcs_pkg::WordAddrW-1:0] word_address;
		logic [nfcs_pkg::DataW-1:0]     bus_data;
		logic                           last;
	} bus_cycle_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;  // [23:0] byte_address, [39:24] data_word
	logic [1:0]  s_axis_tuser  = '0;  // [1:0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [22:0] word_address, [38:23] bus_data, [39] zero
	logic [1:0]  m_axis_tuser;        // [1:0] kind
	logic        m_axis_tlast;

	// sequencer state as predicted
	logic [1:0]                     flash_phase   = nfcs_pkg::PhIdle;
	logic                           flash_toggle  = 1'b0;
	logic [nfcs_pkg::WordAddrW-1:0] flash_target  = '0;
	logic                           flash_seen    = 1'b0;

	bus_cycle_t cycles_due[$];
	bit         request_took_effect;
	int         errors       = 0;
	int         tx_gap_max   = 10;
	int         rx_stall_max = 10;
	int         rx_stall     = 0;
	int         rx_hold      = 0;

	always #10 clk = ~clk;

	nor_flash_command_sequencer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	function automatic void push_cycle(logic [1:0] kind,
			logic [nfcs_pkg::WordAddrW-1:0] addr, logic [nfcs_pkg::DataW-1:0] data);
		bus_cycle_t c;
		c.kind         = kind;
		c.word_address = addr;
		c.bus_data     = data;
		c.last         = 1'b0;
		cycles_due.push_back(c);
	endfunction

	// expands one request into the bus cycles it causes; returns 0 if ignored
	function automatic bit expand_request(logic [1:0] mode,
			logic [nfcs_pkg::ByteAddrW-1:0] byte_address,
			logic [nfcs_pkg::DataW-1:0] data_word);
		logic [nfcs_pkg::WordAddrW-1:0] wa;
		logic                           t;
		int                             first;
		bit                             busy;
		bit                             took;
		bus_cycle_t                     c;
		wa    = byte_address[nfcs_pkg::ByteAddrW-1:1];
		t     = data_word[nfcs_pkg::ToggleBitDefault];
		first = cycles_due.size();
		busy  = (flash_phase == nfcs_pkg::PhPoll) || (flash_phase == nfcs_pkg::PhId);
		took  = 1'b1;
		if (mode != nfcs_pkg::ModeResponse) begin
			if (busy) begin
				took = 1'b0;
			end else if (mode == nfcs_pkg::ModeReadId) begin
				push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdUnlockA);
				push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrB, nfcs_pkg::CmdUnlockB);
				push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdAutoSel);
				push_cycle(nfcs_pkg::KindRead, 23'd0, '0);
				push_cycle(nfcs_pkg::KindRead, 23'd1, '0);
				flash_phase = nfcs_pkg::PhId;
				flash_seen  = 1'b0;
			end else begin
				push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdUnlockA);
				push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrB, nfcs_pkg::CmdUnlockB);
				if (mode == nfcs_pkg::ModeProgram) begin
					push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrA,
						nfcs_pkg::CmdProgram);
					push_cycle(nfcs_pkg::KindWrite, wa, data_word);
				end else begin
					push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrA, nfcs_pkg::CmdErase);
					push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrA,
						nfcs_pkg::CmdUnlockA);
					push_cycle(nfcs_pkg::KindWrite, nfcs_pkg::UnlockAddrB,
						nfcs_pkg::CmdUnlockB);
					push_cycle(nfcs_pkg::KindWrite, wa, nfcs_pkg::CmdSector);
				end
				push_cycle(nfcs_pkg::KindRead, wa, '0);
				push_cycle(nfcs_pkg::KindRead, wa, '0);
				flash_phase  = nfcs_pkg::PhPoll;
				flash_target = wa;
				flash_seen   = 1'b0;
				flash_toggle = 1'b0;
			end
		end else if (flash_phase == nfcs_pkg::PhPoll) begin
			if (!flash_seen) begin
				flash_toggle = t;
				flash_seen   = 1'b1;
			end else if (t == flash_toggle) begin
				push_cycle(nfcs_pkg::KindDone, flash_target, '0);
				flash_phase = nfcs_pkg::PhIdle;
				flash_seen  = 1'b0;
			end else begin
				flash_toggle = t;
				push_cycle(nfcs_pkg::KindRead, flash_target, '0);
			end
		end else if (flash_phase == nfcs_pkg::PhId) begin
			if (!flash_seen) begin
				push_cycle(nfcs_pkg::KindId, 23'd0, data_word);
				flash_seen = 1'b1;
			end else begin
				push_cycle(nfcs_pkg::KindId, 23'd1, data_word);
				push_cycle(nfcs_pkg::KindWrite, 23'd0, nfcs_pkg::CmdReset);
				flash_phase = nfcs_pkg::PhIdle;
				flash_seen  = 1'b0;
			end
		end else begin
			took = 1'b0;
		end
		if (cycles_due.size() > first) begin
			c = cycles_due.pop_back();
			c.last = 1'b1;
			cycles_due.push_back(c);
		end
		return took;
	endfunction

	task automatic send_request(input logic [1:0] mode,
			input logic [nfcs_pkg::ByteAddrW-1:0] addr,
			input logic [nfcs_pkg::DataW-1:0] data);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {data, addr};
		s_axis_tuser  <= mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		request_took_effect = expand_request(mode, addr, data);
	endtask

	// mostly well-formed traffic for the current phase, one in ten is noise
	task automatic send_random_request;
		logic [1:0]                     mode;
		logic [nfcs_pkg::ByteAddrW-1:0] addr;
		logic [nfcs_pkg::DataW-1:0]     data;
		bit                             noise;
		addr  = nfcs_pkg::ByteAddrW'($urandom);
		data  = nfcs_pkg::DataW'($urandom);
		noise = ($urandom_range(0, 9) == 0);
		if (flash_phase == nfcs_pkg::PhPoll || flash_phase == nfcs_pkg::PhId) begin
			mode = noise ? 2'($urandom_range(0, 2)) : nfcs_pkg::ModeResponse;
			if (flash_phase == nfcs_pkg::PhPoll && flash_seen)
				data[nfcs_pkg::ToggleBitDefault] = ($urandom_range(0, 9) < 6) ? ~flash_toggle
					: flash_toggle;
		end else begin
			mode = noise ? nfcs_pkg::ModeResponse : 2'($urandom_range(0, 2));
		end
		send_request(mode, addr, data);
	endtask

	task automatic wait_idle;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (cycles_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_bus_cycle;
		bus_cycle_t want;
		if (cycles_due.size() == 0) begin
			$error("unexpected result: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
			errors++;
		end else begin
			want = cycles_due.pop_front();
			if (m_axis_tuser !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
				errors++;
			end
			if (m_axis_tdata[22:0] !== want.word_address) begin
				$error("word_address: expected %h, actual %h", want.word_address,
					m_axis_tdata[22:0]);
				errors++;
			end
			if (m_axis_tdata[38:23] !== want.bus_data) begin
				$error("bus_data: expected %h, actual %h", want.bus_data, m_axis_tdata[38:23]);
				errors++;
			end
			if (m_axis_tdata[39] !== 1'b0) begin
				$error("tdata pad: expected 0, actual %b", m_axis_tdata[39]);
				errors++;
			end
			if (m_axis_tlast !== want.last) begin
				$error("last: expected %b, actual %b", want.last, m_axis_tlast);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_bus_cycle();
			rx_stall = $urandom_range(0, rx_stall_max);
		end
	end

	// hold-off has priority over the per-result stall
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (rx_stall != 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_program_word;
		send_request(nfcs_pkg::ModeProgram, 24'h000000, 16'h0000);
		send_request(nfcs_pkg::ModeResponse, 24'hFFFFFF, 16'h0000);
		send_request(nfcs_pkg::ModeResponse, 24'hFFFFFF, 16'h0040);  // still toggling
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'hFFFF);
		send_request(nfcs_pkg::ModeProgram, 24'hFFFFFF, 16'hFFFF);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'hFFBF);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0000);
		wait_idle();
	endtask

	task automatic test_sector_erase;
		send_request(nfcs_pkg::ModeErase, 24'h012345, 16'hA5A5);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0040);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0000);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0040);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0040);
		send_request(nfcs_pkg::ModeErase, 24'hFFFFFE, 16'h0000);
		send_request(nfcs_pkg::ModeResponse, 24'hABCDEF, 16'hFFFF);
		send_request(nfcs_pkg::ModeResponse, 24'hABCDEF, 16'hFFFF);
		wait_idle();
	endtask

	task automatic test_read_ids;
		send_request(nfcs_pkg::ModeReadId, 24'h000000, 16'h0000);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0001);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h227E);
		send_request(nfcs_pkg::ModeReadId, 24'hFFFFFF, 16'hFFFF);
		send_request(nfcs_pkg::ModeResponse, 24'hFFFFFF, 16'hFFFF);
		send_request(nfcs_pkg::ModeResponse, 24'hFFFFFF, 16'h0000);
		wait_idle();
	endtask

	task automatic test_ignored_requests;
		send_request(nfcs_pkg::ModeResponse, 24'h000002, 16'h0040);  // nothing in flight
		send_request(nfcs_pkg::ModeProgram, 24'h000100, 16'h1234);
		send_request(nfcs_pkg::ModeErase, 24'h000200, 16'h0000);     // busy polling
		send_request(nfcs_pkg::ModeReadId, 24'h000300, 16'h0000);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0040);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h0040);
		send_request(nfcs_pkg::ModeReadId, 24'h000000, 16'h0000);
		send_request(nfcs_pkg::ModeProgram, 24'h000400, 16'h5555);   // busy reading ids
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h00C2);
		send_request(nfcs_pkg::ModeResponse, 24'h000000, 16'h22DA);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int count);
		int n;
		tx_gap_max   = 10;
		rx_stall_max = 10;
		n = 0;
		while (n < count) begin
			send_random_request();
			if (request_took_effect) n++;
		end
		wait_idle();
	endtask

	task automatic test_back_to_back(input int count);
		int n;
		tx_gap_max   = 0;
		rx_stall_max = 0;
		n = 0;
		while (n < count) begin
			send_random_request();
			if (request_took_effect) n++;
		end
		wait_idle();
	endtask

	// receiver stops for a long stretch while requests keep coming
	task automatic test_output_backpressure(input int count);
		int n;
		tx_gap_max   = 0;
		rx_stall_max = 3;
		rx_hold      = 400;
		n = 0;
		while (n < count) begin
			send_random_request();
			if (request_took_effect) n++;
		end
		wait_idle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_program_word();
		test_sector_erase();
		test_read_ids();
		test_ignored_requests();
		test_random_traffic(140);
		test_back_to_back(90);
		test_output_backpressure(30);
		test_random_traffic(100);
		if (errors == 0 && cycles_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
